/* hw/rtl/dqs_pkg.sv */
// dqs_pkg: shared types and codes for the deque with linear search
// request codes, status codes, sequencer states and fixed field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

	localparam int DATA_W = 32;
	localparam int REQ_W  = 3;
	localparam int STAT_W = 2;
	localparam int OUT_W  = 7;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		DQS_IDLE,
		DQS_SEARCH,
		DQS_RESP
	} dqs_state_t;

endpackage

`default_nettype wire

/* hw/rtl/deque_with_linear_search_unit.sv */
// deque_with_linear_search_unit: top level of the bounded deque with front search
// depends on dqs_pkg and dqs_ram (ring store of entries)
`timescale 1ns / 1ps
`default_nettype none

// A bounded double-ended queue of DEPTH signed 32-bit entries held in a ring
// memory. Each request transaction pushes or pops at either end or searches
// from the front for the first entry equal to value, and yields exactly one
// response transaction with status, 1-based match position and the entry count
// after the request. One request is handled at a time. A push, a pop, an unused
// code or a search of an empty store goes from acceptance straight to the
// response state. A search over n held entries walks the ring one entry per
// cycle through the single read port of the memory, with registered read data
// before each compare, and ends at the first match or after the last entry.
// The response register lets the next request be accepted while a finished
// response is still stalled.
module deque_with_linear_search_unit #(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic        [dqs_pkg::REQ_W-1:0]  req_type,
	input  wire logic signed [dqs_pkg::DATA_W-1:0] value,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic             [dqs_pkg::STAT_W-1:0] status,
	output logic             [dqs_pkg::OUT_W-1:0]  position,
	output logic             [dqs_pkg::OUT_W-1:0]  count
);

	import dqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int OW_PAD = OUT_W;

	dqs_state_t state_q, state_d;

	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     slot_q;
	logic [CW-1:0]     idx_q;
	logic              chk_s1;
	logic [CW-1:0]     off_s1;
	logic [DATA_W-1:0] key_q;
	logic [STAT_W-1:0] res_status_q;
	logic [CW-1:0]     res_pos_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [OUT_W-1:0]  out_pos_q;
	logic [OUT_W-1:0]  out_count_q;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	logic [AW-1:0]     front_dec;
	logic [AW-1:0]     front_inc;
	logic [AW-1:0]     slot_inc;
	logic [SW-1:0]     back_sum;
	logic [AW-1:0]     back_slot;
	logic              issue;
	logic              hit;
	logic              last;
	logic              out_free;
	logic              load;
	logic [STAT_W-1:0] acc_status;
	logic [CW+OW_PAD-1:0] cnt_ext;
	logic [CW+OW_PAD-1:0] pos_ext;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	dqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ring arithmetic
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign slot_inc  = (slot_q == AW'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign back_sum  = {1'b0, front_q} + SW'(count_q);
	assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
		: back_sum[AW-1:0];

	assign accept   = req_valid && !req_stall;
	assign out_free = !out_valid_q || !rsp_stall;
	assign issue    = (state_q == DQS_SEARCH) && (idx_q != count_q);
	assign hit      = (state_q == DQS_SEARCH) && chk_s1 && (ram_rdata == key_q);
	assign last     = (state_q == DQS_SEARCH) && chk_s1
		&& (off_s1 == count_q - 1'b1);

	always_comb begin
		acc_status = STAT_OK;
		case (req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (is_full) acc_status = STAT_FULL;
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (is_empty) acc_status = STAT_EMPTY;
			end
			REQ_SEARCH: acc_status = STAT_NOT_FOUND;
			default: acc_status = STAT_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DQS_IDLE: begin
				if (accept) begin
					if (req_type == REQ_SEARCH && !is_empty) state_d = DQS_SEARCH;
					else state_d = DQS_RESP;
				end
			end
			DQS_SEARCH: begin
				if (hit || last) state_d = DQS_RESP;
			end
			DQS_RESP: begin
				if (out_free) state_d = DQS_IDLE;
			end
			default: state_d = DQS_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall = 1'b1;
		load      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = back_slot;
		ram_raddr = slot_q;
		unique case (state_q)
			DQS_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && !is_full) begin
					if (req_type == REQ_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = front_dec;
					end else if (req_type == REQ_PUSH_BACK) begin
						ram_we = 1'b1;
					end
				end
			end
			DQS_SEARCH: begin
				req_stall = 1'b1;
			end
			DQS_RESP: begin
				load = out_free;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DQS_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= issue;
			if (accept) begin
				case (req_type)
					REQ_PUSH_FRONT: begin
						if (!is_full) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end
					end
					REQ_PUSH_BACK: begin
						if (!is_full) count_q <= count_q + 1'b1;
					end
					REQ_POP_FRONT: begin
						if (!is_empty) begin
							front_q <= front_inc;
							count_q <= count_q - 1'b1;
						end
					end
					REQ_POP_BACK: begin
						if (!is_empty) count_q <= count_q - 1'b1;
					end
					default: ;
				endcase
			end
			if (load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	assign cnt_ext = {{OW_PAD{1'b0}}, count_q};
	assign pos_ext = {{OW_PAD{1'b0}}, res_pos_q};

	// payload registers
	always_ff @(posedge clk) begin
		off_s1 <= idx_q;
		if (accept) begin
			key_q        <= value;
			slot_q       <= front_q;
			idx_q        <= '0;
			res_status_q <= acc_status;
			res_pos_q    <= '0;
		end else if (issue) begin
			slot_q <= slot_inc;
			idx_q  <= idx_q + 1'b1;
		end
		if (hit) begin
			res_status_q <= STAT_OK;
			res_pos_q    <= off_s1 + 1'b1;
		end
		if (load) begin
			out_status_q <= res_status_q;
			out_pos_q    <= pos_ext[OUT_W-1:0];
			out_count_q  <= cnt_ext[OUT_W-1:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign position  = out_pos_q;
	assign count     = out_count_q;

endmodule

`default_nettype wire

/* hw/rtl/dqs_ram.sv */
// dqs_ram: generic single-write, single-read memory with registered read data
// width and depth are parameters; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* bench/deque_with_linear_search_unit_tb.sv */
// deque_with_linear_search_unit_tb: self-checking bench for the deque with front search
// keeps a shadow copy of the ring to predict each response, with random gaps and backpressure
// depends on dqs_pkg and deque_with_linear_search_unit
`timescale 1ns / 1ps

module deque_with_linear_search_unit_tb;
	import dqs_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = DEPTH + 16;
	localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_LAST = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OUT_W-1:0] position;
		logic [OUT_W-1:0] count;
	} deque_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [REQ_W-1:0] req_type = REQ_PUSH_FRONT;
	logic signed [DATA_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [OUT_W-1:0] position;
	logic [OUT_W-1:0] count;

	logic signed [DATA_W-1:0] shadow_mem [DEPTH];
	logic [IDX_W-1:0] shadow_head = '0;
	int shadow_fill = 0;

	deque_rsp_t pending_responses [$];
	deque_rsp_t want;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int kind_seen [8];
	int status_seen [4];
	int peak_fill = 0;

	deque_with_linear_search_unit #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position),
		.count(count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [IDX_W-1:0] ring_slot(int offset);
		return IDX_W'(int'(shadow_head) + offset);
	endfunction

	function automatic deque_rsp_t predict_response(logic [REQ_W-1:0] kind,
			logic signed [DATA_W-1:0] key);
		deque_rsp_t r;
		bit found;
		r.status = STAT_OK;
		r.position = '0;
		found = 1'b0;
		case (kind)
		REQ_PUSH_FRONT: begin
			if (shadow_fill == DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_head = shadow_head - 1'b1;
				shadow_mem[shadow_head] = key;
				shadow_fill++;
			end
		end
		REQ_PUSH_BACK: begin
			if (shadow_fill == DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_mem[ring_slot(shadow_fill)] = key;
				shadow_fill++;
			end
		end
		REQ_POP_FRONT: begin
			if (shadow_fill == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				shadow_head = shadow_head + 1'b1;
				shadow_fill--;
			end
		end
		REQ_POP_BACK: begin
			if (shadow_fill == 0)
				r.status = STAT_EMPTY;
			else
				shadow_fill--;
		end
		REQ_SEARCH: begin
			r.status = STAT_NOT_FOUND;
			for (int k = 0; k < shadow_fill; k++) begin
				if (!found && shadow_mem[ring_slot(k)] == key) begin
					found = 1'b1;
					r.status = STAT_OK;
					r.position = OUT_W'(k + 1);
				end
			end
		end
		default: begin
		end
		endcase
		r.count = OUT_W'(shadow_fill);
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(0, 7))
		0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		1, 2, 3: return int'($urandom_range(0, 8)) - 4;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_held_value();
		return shadow_mem[ring_slot(int'($urandom_range(0, shadow_fill - 1)))];
	endfunction

	function automatic logic signed [DATA_W-1:0] search_key();
		if (shadow_fill > 0 && $urandom_range(0, 9) < 7)
			return pick_held_value();
		return random_value();
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// drives one request transaction and records its predicted response once accepted
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic signed [DATA_W-1:0] key);
		int gap;
		deque_rsp_t r;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		value <= key;
		do @(posedge clk); while (req_stall);
		r = predict_response(kind, key);
		pending_responses.push_back(r);
		kind_seen[kind]++;
		status_seen[r.status]++;
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
	endtask

	// receiver side: random stall per response, plus long holds on request
	initial begin
		int n;
		forever begin
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			n = idle_on ? $urandom_range(0, 10) : 0;
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid && hold_cycles == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_responses.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", status, want.status));
				if (position !== want.position)
					report_mismatch($sformatf("position got %0d want %0d", position,
						want.position));
				if (count !== want.count)
					report_mismatch($sformatf("count got %0d want %0d", count, want.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_empty_store();
		send_request(REQ_POP_FRONT, random_value());
		send_request(REQ_POP_BACK, random_value());
		send_request(REQ_SEARCH, '0);
		for (int c = REQ_RSVD_FIRST; c <= REQ_RSVD_LAST; c++)
			send_request(REQ_W'(c), random_value());
	endtask

	task automatic test_extremes();
		send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
		send_request(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
		send_request(REQ_PUSH_FRONT, '0);
		send_request(REQ_PUSH_BACK, -1);
		send_request(REQ_PUSH_BACK, '0);
		send_request(REQ_SEARCH, 32'sh8000_0000);
		send_request(REQ_SEARCH, 32'sh7FFF_FFFF);
		send_request(REQ_SEARCH, '0);
		send_request(REQ_SEARCH, -1);
		send_request(REQ_SEARCH, 1);
		send_request(REQ_RSVD_LAST, 32'sh5555_AAAA);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_POP_FRONT, -1);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_POP_FRONT, '0);
	endtask

	task automatic test_fill_and_drain();
		logic signed [DATA_W-1:0] marker;
		marker = $urandom | 32'h4000_0000;
		while (shadow_fill < DEPTH - 1)
			send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, random_value());
		send_request(REQ_PUSH_BACK, marker);
		send_request(REQ_PUSH_FRONT, random_value());
		send_request(REQ_PUSH_BACK, random_value());
		send_request(REQ_SEARCH, marker);
		for (int k = 0; k < 6; k++)
			send_request(REQ_SEARCH, search_key());
		while (shadow_fill > 0) begin
			if ($urandom_range(0, 7) == 0)
				send_request(REQ_SEARCH, search_key());
			else
				send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, '0);
		end
		send_request(REQ_POP_BACK, random_value());
		send_request(REQ_SEARCH, marker);
	endtask

	task automatic test_random_mix(input int items);
		int pick;
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				send_request(REQ_PUSH_FRONT, random_value());
			else if (pick < 40)
				send_request(REQ_PUSH_BACK, random_value());
			else if (pick < 58)
				send_request(REQ_POP_FRONT, random_value());
			else if (pick < 76)
				send_request(REQ_POP_BACK, random_value());
			else if (pick < 97)
				send_request(REQ_SEARCH, search_key());
			else
				send_request(REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST)), random_value());
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_cycles = 300;
		for (int k = 0; k < 40; k++)
			send_request($urandom_range(0, 2) == 0 ? REQ_SEARCH : REQ_PUSH_BACK, search_key());
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extremes();
		test_random_mix(150);
		idle_on = 1'b0;
		test_random_mix(60);
		idle_on = 1'b1;
		test_fill_and_drain();
		test_backpressure();
		test_random_mix(120);
		req_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests: %0d push front, %0d push back, %0d pop front, %0d pop back, %0d search",
			kind_seen[REQ_PUSH_FRONT], kind_seen[REQ_PUSH_BACK], kind_seen[REQ_POP_FRONT],
			kind_seen[REQ_POP_BACK], kind_seen[REQ_SEARCH]);
		$display("statuses: %0d ok, %0d empty, %0d full, %0d miss; peak fill %0d of %0d",
			status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
			status_seen[STAT_NOT_FOUND], peak_fill, DEPTH);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
